/* hdl/sorted_sample_cdf_quantile_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted sample CDF and quantile engine
// Shared clocked, reset-qualified assertion forms.
// ----------------------------------------------------------------------------
`ifndef SORTED_SAMPLE_CDF_QUANTILE_TOP_MACROS_SVH
`define SORTED_SAMPLE_CDF_QUANTILE_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SSCQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SSCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sscq_pkg.sv */
// ----------------------------------------------------------------------------
// sscq_pkg
// Types and constants shared by the sorted sample CDF and quantile engine.
// ----------------------------------------------------------------------------
package sscq_pkg;

  localparam logic [2:0] MODE_CLEAR    = 3'd0;
  localparam logic [2:0] MODE_INSERT   = 3'd1;
  localparam logic [2:0] MODE_CDF      = 3'd2;
  localparam logic [2:0] MODE_EXCEED   = 3'd3;
  localparam logic [2:0] MODE_QUANTILE = 3'd4;
  localparam logic [2:0] MODE_SUMMARY  = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NONFIN  = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [16:0]        prob;
    logic               not_finite;
  } req_t;

  typedef struct packed {
    logic [16:0]        fraction;
    logic signed [31:0] quantile_value;
    logic [10:0]        sample_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [1:0]         status;
  } rsp_t;

endpackage

/* hdl/sscq_stream_if.sv */
// ----------------------------------------------------------------------------
// sscq_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface sscq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/sorted_sample_cdf_quantile_top.sv */
// ----------------------------------------------------------------------------
// sorted_sample_cdf_quantile_top
// Sorted sample store with CDF, exceedance, quantile and summary queries.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_ch   | sink      | mode, value, prob, not_finite
// out_ch  | source    | fraction, quantile_value, sample_count, min/max, status
//
// An insert runs a binary search, then moves each entry above the insert point
// up one place and writes the new sample; the single RAM port serializes these
// steps. CDF and exceed run the search and then the divider. A quantile reads
// two neighboring samples and interpolates; every request then reads min/max.
// Reset clears the count only; the store holds no contents that matter.
// The front queue takes up to two items while the engine is busy or its
// result waits on a stalled output transfer.
`include "sorted_sample_cdf_quantile_top_macros.svh"

module sorted_sample_cdf_quantile_top #(
  parameter int CAPACITY = 1024
) (
  input logic         clk,
  input logic         rst,
  sscq_stream_if.sink   in_ch,
  sscq_stream_if.source out_ch
);
  logic           q_valid;
  logic           q_pop;
  sscq_pkg::req_t q_data;

  sscq_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  sscq_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );

  // The engine never takes a request it has no queue entry for.
  `SSCQ_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  // A result never reports a count beyond the capacity.
  `SSCQ_ASSERT_IMP(a_count_cap, out_ch.valid,
    out_ch.data.sample_count <= 11'(CAPACITY), "count over capacity")
  // An empty store reports zero extremes.
  `SSCQ_ASSERT_IMP(a_empty_zero, out_ch.valid && out_ch.data.sample_count == '0,
    out_ch.data.min_value == '0, "nonzero min on empty store")
endmodule

/* hdl/sscq_ram.sv */
// ----------------------------------------------------------------------------
// sscq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sscq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/sscq_front.sv */
// ----------------------------------------------------------------------------
// sscq_front
// Accepts requests and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module sscq_front (
  input  logic             clk,
  input  logic             rst,
  sscq_stream_if.sink      in_ch,
  output logic             q_valid,
  output sscq_pkg::req_t   q_data,
  input  logic             q_pop
);
  sscq_pkg::req_t slot [2];
  logic [1:0]     fill;
  logic           rd_ptr;
  logic           wr_ptr;
  logic           push;

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != 2'd0);
  assign q_data      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_ch.data;
    end
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* hdl/sscq_divider.sv */
// ----------------------------------------------------------------------------
// sscq_divider
// Restoring divider, one quotient bit per cycle, for k*65536/n.
// ----------------------------------------------------------------------------
module sscq_divider #(
  parameter int NW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num_k,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [16:0]   quot
);
  localparam int DW = NW + 16;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dividend;
  logic [NW:0]   rem;
  logic [NW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   trial;

  assign trial = {rem[NW-1:0], dividend[DW-1]};
  assign quot  = dividend[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        dividend <= {num_k, 16'd0};
        rem      <= '0;
        dsr      <= den;
        cnt      <= CW'(DW);
        busy     <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem      <= trial - {1'b0, dsr};
          dividend <= {dividend[DW-2:0], 1'b1};
        end else begin
          rem      <= trial;
          dividend <= {dividend[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

/* hdl/sscq_engine.sv */
// ----------------------------------------------------------------------------
// sscq_engine
// Executes one request at a time against the sorted sample memory.
// ----------------------------------------------------------------------------
module sscq_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sscq_pkg::req_t q_data,
  output logic           q_pop,
  sscq_stream_if.source  out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_SHIFT_RD, S_SHIFT_W, S_WRITE, S_DIV,
    S_Q_RD0, S_Q_RD1, S_Q_MUL, S_Q_SUM, S_MINMAX0, S_MINMAX1, S_MAX, S_OUT
  } state_t;

  state_t          state;
  state_t          start_state;
  logic [1:0]      start_status;
  sscq_pkg::req_t  req;
  logic [NW-1:0]   count;
  logic [NW-1:0]   lo;
  logic [NW-1:0]   hi;
  logic [NW-1:0]   mid;
  logic [NW-1:0]   ptr;
  logic signed [31:0] x0;
  logic [15:0]     gfrac;
  logic [NW-1:0]   jidx;
  logic signed [49:0] prod0;
  logic signed [49:0] prod1;
  logic            strict;
  sscq_pkg::rsp_t  rsp;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [31:0]     ram_wdata;
  logic [31:0]     ram_rdata;
  logic signed [31:0] rd_s;

  logic            div_start;
  logic            div_done;
  logic [16:0]     div_q;
  logic [16:0]     p_sat;
  logic [NW+16:0]  pos;
  logic            goes_left;
  logic signed [50:0] qsum;

  sscq_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  sscq_divider #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num_k(lo), .den(count),
    .done(div_done), .quot(div_q)
  );

  assign rd_s      = $signed(ram_rdata);
  assign goes_left = strict ? (rd_s < req.value) : (rd_s <= req.value);
  assign mid       = lo + ((hi - lo) >> 1);
  assign p_sat     = (q_data.prob > sscq_pkg::ONE_Q16) ? sscq_pkg::ONE_Q16 : q_data.prob;
  assign pos       = (NW + 17)'(count - 1'b1) * (NW + 17)'(p_sat);
  assign qsum      = 51'(prod0) + 51'(prod1) + 51'sd32768;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_SRCH) && (lo >= hi) &&
                     (req.mode != sscq_pkg::MODE_INSERT);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = rsp;

  // Classification of a new request: first state and initial status.
  always_comb begin
    start_status = sscq_pkg::STATUS_OK;
    start_state  = S_MINMAX0;
    unique case (q_data.mode)
      sscq_pkg::MODE_INSERT: begin
        if (q_data.not_finite) begin
          start_status = sscq_pkg::STATUS_NONFIN;
        end else if (count >= NW'(CAPACITY)) begin
          start_status = sscq_pkg::STATUS_FULL;
        end else begin
          start_state = S_SRCH;
        end
      end
      sscq_pkg::MODE_CDF, sscq_pkg::MODE_EXCEED, sscq_pkg::MODE_QUANTILE: begin
        if (q_data.not_finite) begin
          start_status = sscq_pkg::STATUS_NONFIN;
        end else if (count != '0) begin
          start_state = (q_data.mode == sscq_pkg::MODE_QUANTILE) ? S_Q_RD0 : S_SRCH;
        end
      end
      default: begin
        start_state = S_MINMAX0;
      end
    endcase
  end

  // Memory port usage per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = req.value;
    ram_addr  = AW'(mid);
    unique case (state)
      S_SHIFT_RD: ram_addr = AW'(ptr - 1'b1);
      S_SHIFT_W: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(ptr);
        ram_wdata = ram_rdata;
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = AW'(lo);
      end
      S_Q_RD0:   ram_addr = AW'(jidx);
      S_Q_RD1:   ram_addr = AW'(jidx + 1'b1);
      S_MINMAX0: ram_addr = '0;
      S_MINMAX1: ram_addr = AW'(count - 1'b1);
      default:   ram_addr = AW'(mid);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            req    <= q_data;
            strict <= (q_data.mode == sscq_pkg::MODE_EXCEED);
            lo     <= '0;
            hi     <= count;
            jidx   <= NW'(pos >> 16);
            gfrac  <= pos[15:0];
            rsp    <= {17'd0, 32'd0, 11'd0, 32'd0, 32'd0, start_status};
            if (q_data.mode == sscq_pkg::MODE_CLEAR) begin
              count <= '0;
            end
            state <= start_state;
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            state <= S_SRCH_W;
          end else if (req.mode == sscq_pkg::MODE_INSERT) begin
            ptr   <= count;
            state <= S_SHIFT_RD;
          end else begin
            state <= S_DIV;
          end
        end
        S_SRCH_W: begin
          if (goes_left) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_SHIFT_RD: begin
          state <= (ptr > lo) ? S_SHIFT_W : S_WRITE;
        end
        S_SHIFT_W: begin
          ptr   <= ptr - 1'b1;
          state <= S_SHIFT_RD;
        end
        S_WRITE: begin
          count <= count + 1'b1;
          state <= S_MINMAX0;
        end
        S_DIV: begin
          if (div_done) begin
            rsp.fraction <= strict ? (sscq_pkg::ONE_Q16 - div_q) : div_q;
            state        <= S_MINMAX0;
          end
        end
        S_Q_RD0: begin
          state <= S_Q_RD1;
        end
        S_Q_RD1: begin
          x0    <= rd_s;
          state <= S_Q_MUL;
        end
        S_Q_MUL: begin
          prod0 <= 50'($signed({1'b0, 17'd65536 - {1'b0, gfrac}}) * x0);
          prod1 <= 50'($signed({1'b0, gfrac}) * rd_s);
          state <= S_Q_SUM;
        end
        S_Q_SUM: begin
          // At the top order statistic the answer is that sample itself.
          rsp.quantile_value <= (jidx + 1'b1 >= count) ? x0 : 32'(qsum >>> 16);
          state              <= S_MINMAX0;
        end
        S_MINMAX0: begin
          state <= S_MINMAX1;
        end
        S_MINMAX1: begin
          rsp.min_value    <= (count == '0) ? '0 : rd_s;
          rsp.sample_count <= 11'(count);
          state            <= S_MAX;
        end
        S_MAX: begin
          rsp.max_value <= (count == '0) ? '0 : rd_s;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* test/sscq_test_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sscq_test_pkg
// Constants shared by the testbench processes.
// ----------------------------------------------------------------------------
package sscq_test_pkg;
  // Upper bound of the long random gaps a driver or the receiver inserts between transfers.
  localparam int LONG_GAP = 40;

  // Mode codes the block leaves unused.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
endpackage

/* test/sorted_sample_cdf_quantile_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted sample CDF and quantile engine test
// Drives clear, insert, cdf, exceed, quantile and summary operations through
// the input channel, predicts each result from a sorted shadow copy of the
// store, and compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
module sorted_sample_cdf_quantile_top_test;
  localparam int CAP = 1024;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sscq_stream_if #(.payload_t(sscq_pkg::req_t)) in_ch ();
  sscq_stream_if #(.payload_t(sscq_pkg::rsp_t)) out_ch ();

  sorted_sample_cdf_quantile_top #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the block's sorted store and its occupancy.
  logic signed [31:0] shadow_samples[$];
  sscq_pkg::rsp_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit hold_output = 1'b0;

  // Number of held samples at or below v, or strictly below when strict.
  function automatic int count_at_or_below(logic signed [31:0] v, bit strict);
    int k;
    k = 0;
    foreach (shadow_samples[i])
      if (strict ? (shadow_samples[i] < v) : (shadow_samples[i] <= v)) k++;
    return k;
  endfunction

  // Type 7 interpolation between neighboring order statistics.
  function automatic logic signed [31:0] interpolate_quantile(logic [16:0] prob);
    longint n, p, pos, j, g, s;
    n = shadow_samples.size();
    p = (prob > sscq_pkg::ONE_Q16) ? 65536 : prob;
    pos = (n - 1) * p;
    j = pos >>> 16;
    g = pos & 64'hFFFF;
    if (n == 1 || j + 1 >= n) return shadow_samples[n-1];
    s = (65536 - g) * longint'(shadow_samples[j]) + g * longint'(shadow_samples[j+1]);
    s = s + 32768;
    // Arithmetic shift gives floor division for negative sums too.
    return 32'(s >>> 16);
  endfunction

  // Applies one operation to the shadow store and returns the expected result.
  function automatic sscq_pkg::rsp_t apply_operation(sscq_pkg::req_t r);
    sscq_pkg::rsp_t e;
    int at, n;
    e = '0;
    n = shadow_samples.size();
    unique case (r.mode)
      sscq_pkg::MODE_CLEAR: shadow_samples.delete();
      sscq_pkg::MODE_INSERT: begin
        if (r.not_finite) e.status = sscq_pkg::STATUS_NONFIN;
        else if (n >= CAP) e.status = sscq_pkg::STATUS_FULL;
        else begin
          at = count_at_or_below(r.value, 1'b0);
          shadow_samples.insert(at, r.value);
        end
      end
      sscq_pkg::MODE_CDF, sscq_pkg::MODE_EXCEED, sscq_pkg::MODE_QUANTILE: begin
        if (r.not_finite) e.status = sscq_pkg::STATUS_NONFIN;
        else if (n != 0) begin
          if (r.mode == sscq_pkg::MODE_CDF)
            e.fraction = 17'((longint'(count_at_or_below(r.value, 1'b0)) * 65536) / n);
          else if (r.mode == sscq_pkg::MODE_EXCEED)
            e.fraction = 17'(65536 -
                (longint'(count_at_or_below(r.value, 1'b1)) * 65536) / n);
          else
            e.quantile_value = interpolate_quantile(r.prob);
        end
      end
      default: ;
    endcase
    n = shadow_samples.size();
    e.sample_count = 11'(n);
    e.min_value = n ? shadow_samples[0] : '0;
    e.max_value = n ? shadow_samples[n-1] : '0;
    return e;
  endfunction

  // Sends one item, with a random gap ahead of it, and records its prediction.
  // Valid stays high after a transfer when the next item follows directly.
  task automatic send_item(sscq_pkg::req_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, sscq_test_pkg::LONG_GAP)
                                      : $urandom_range(0, 2);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    pending_results = {pending_results, apply_operation(r)};
  endtask

  task automatic send_op(logic [2:0] m, logic signed [31:0] v, logic [16:0] p, bit nf);
    sscq_pkg::req_t r;
    r.mode = m; r.value = v; r.prob = p; r.not_finite = nf;
    send_item(r);
  endtask

  // Waits until every predicted result has been checked.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver readiness: mostly short stalls, now and then a long one, and a
  // held-off stretch on request.
  always @(posedge clk) begin
    if (rst || hold_output) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_ch.ready <= 1'b0;
      rx_wait <= $urandom_range(5, sscq_test_pkg::LONG_GAP);
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Checks each output transfer against the oldest prediction.
  always @(posedge clk) begin
    sscq_pkg::rsp_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", a);
      end else begin
        e = pending_results.pop_front();
        if (a !== e) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: exp frac=%0d q=%0d n=%0d min=%0d max=%0d st=%0d",
                      " / act frac=%0d q=%0d n=%0d min=%0d max=%0d st=%0d"},
                     e.fraction, e.quantile_value, e.sample_count, e.min_value,
                     e.max_value, e.status, a.fraction, a.quantile_value,
                     a.sample_count, a.min_value, a.max_value, a.status);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20) - 10;
      1: return 32'($urandom_range(0, 7)) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Extremes of each field, every mode, and the special cases on small stores.
  task automatic test_directed;
    send_op(sscq_pkg::MODE_CDF, 0, 0, 0);                 // Empty store answers zero.
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd32768, 0);
    send_op(sscq_pkg::MODE_SUMMARY, 0, 0, 1);             // Flag ignored on summary.
    send_op(sscq_pkg::MODE_INSERT, 32'sh7FFFFFFF, 0, 0);
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd40000, 0);    // Single sample.
    send_op(sscq_pkg::MODE_INSERT, 32'sh80000000, 0, 0);
    send_op(sscq_pkg::MODE_INSERT, 32'sh00010000, 0, 0);
    send_op(sscq_pkg::MODE_INSERT, 32'sh00010000, 0, 0);  // Equal samples.
    send_op(sscq_pkg::MODE_INSERT, 5, 0, 1);              // Non-finite insert.
    send_op(sscq_pkg::MODE_CDF, 32'sh00010000, 0, 0);
    send_op(sscq_pkg::MODE_EXCEED, 32'sh00010000, 0, 0);
    send_op(sscq_pkg::MODE_CDF, 32'sh80000000, 0, 0);
    send_op(sscq_pkg::MODE_EXCEED, 32'sh7FFFFFFF, 0, 0);
    send_op(sscq_pkg::MODE_EXCEED, 3, 0, 1);              // Non-finite query.
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd0, 0);
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd65536, 0);
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'h1FFFF, 0);    // Probability above one.
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd21845, 0);
    send_op(sscq_pkg::MODE_QUANTILE, 0, 17'd100, 1);
    send_op(sscq_test_pkg::MODE_SPARE_LO, 32'hFFFFFFFF, 17'h1FFFF, 1);  // Unused modes.
    send_op(sscq_test_pkg::MODE_SPARE_HI, 0, 0, 0);
    send_op(sscq_pkg::MODE_CLEAR, 0, 0, 1);
    send_op(sscq_pkg::MODE_SUMMARY, 0, 0, 0);
  endtask

  // Output held off while inputs keep coming, so the front queue fills.
  task automatic test_output_stall;
    hold_output = 1'b1;
    fork
      for (int i = 0; i < 8; i++) send_op(sscq_pkg::MODE_INSERT, random_sample(), 0, 0);
      begin
        repeat (3000) @(posedge clk);
        hold_output = 1'b0;
      end
    join
  endtask

  // Random sessions: an optional clear, then a batch of mixed operations weighted toward inserts.
  task automatic test_random;
    sscq_pkg::req_t r;
    for (int sent = 0; sent < 510; ) begin
      if ($urandom_range(0, 2) == 0) begin
        send_op(sscq_pkg::MODE_CLEAR, 0, 0, 0);
        sent++;
      end
      repeat ($urandom_range(1, 20)) begin
        r.mode = ($urandom_range(0, 3) == 0) ? sscq_pkg::MODE_INSERT
                                             : 3'($urandom_range(1, 7));
        r.value = (r.mode == sscq_pkg::MODE_INSERT || $urandom_range(0, 1))
                  ? random_sample() : $urandom;
        r.prob = ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                             : 17'($urandom_range(0, 65536));
        r.not_finite = ($urandom_range(0, 15) == 0);
        send_item(r);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_stall();
    test_random();
    drain();
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/sscq_pkg.sv
hdl/sscq_stream_if.sv
hdl/sscq_ram.sv
hdl/sscq_front.sv
hdl/sscq_divider.sv
hdl/sscq_engine.sv
hdl/sorted_sample_cdf_quantile_top.sv
test/sscq_test_if.sv
test/sorted_sample_cdf_quantile_top_test.sv
